### design/maw_pkg.sv
// Shared types, codes and constants for the motor arming watchdog.
package maw_pkg;

	localparam int KIND_W     = 3;
	localparam int SIGN_W     = 2;
	localparam int DUTY_W     = 11;
	localparam int TIME_W     = 32;
	localparam int CONN_W     = 3;
	localparam int PHASE_W    = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [DUTY_W-1:0] DUTY_LIMIT_DEF     = 11'd1000;
	localparam logic [TIME_W-1:0] WATCHDOG_LIMIT_DEF = 32'd60000;

	localparam logic [CONN_W-1:0] CONN_MIN = 3'd1;
	localparam logic [CONN_W-1:0] CONN_MAX = 3'd4;

	localparam logic [SIGN_W-1:0] SIGN_POS  = 2'b01;
	localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'b11;
	localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'b00;

	typedef enum logic [KIND_W-1:0] {
		KIND_COMMIT    = 3'd0,
		KIND_ARM       = 3'd1,
		KIND_RUN       = 3'd2,
		KIND_HEARTBEAT = 3'd3,
		KIND_STOP      = 3'd4,
		KIND_RESET     = 3'd5,
		KIND_SERVICE   = 3'd6
	} kind_t;

	typedef enum logic [PHASE_W-1:0] {
		PH_UNCONF   = 3'd0,
		PH_DISARMED = 3'd1,
		PH_ARMED    = 3'd2,
		PH_RUNNING  = 3'd3,
		PH_FAULT    = 3'd4
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CONNECTOR = 3'd0,
		CFG_MOTOR_POL = 3'd1,
		CFG_ENC_POL   = 3'd2,
		CFG_CEILING   = 3'd3,
		CFG_WATCHDOG  = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SIGN_W-1:0] direction_request;
		logic [DUTY_W-1:0] duty_request;
		logic [TIME_W-1:0] time_now;
	} cmd_t;

	typedef struct packed {
		logic              accepted;
		phase_t            phase_code;
		logic [SIGN_W-1:0] direction_held;
		logic [SIGN_W-1:0] drive_direction;
		logic [DUTY_W-1:0] duty_applied;
		logic              drive_enabled;
	} rsp_t;

	typedef struct packed {
		logic [CONN_W-1:0] connector_number;
		logic [SIGN_W-1:0] motor_polarity;
		logic [SIGN_W-1:0] encoder_polarity;
		logic [DUTY_W-1:0] duty_ceiling;
		logic [TIME_W-1:0] watchdog_period;
	} cfg_t;

	function automatic logic sign_ok(input logic [SIGN_W-1:0] s);
		return (s == SIGN_POS) || (s == SIGN_NEG);
	endfunction

endpackage

### design/maw_ifs.sv
// Handshake channel interfaces: command in, response out, config write.
interface maw_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [maw_pkg::KIND_W-1:0]   kind;
	logic [maw_pkg::SIGN_W-1:0]   direction_request;
	logic [maw_pkg::DUTY_W-1:0]   duty_request;
	logic [maw_pkg::TIME_W-1:0]   time_now;

	modport source (output valid, kind, direction_request, duty_request, time_now,
		input ready);
	modport sink (input valid, kind, direction_request, duty_request, time_now,
		output ready);
endinterface

interface maw_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         accepted;
	logic [maw_pkg::PHASE_W-1:0]  phase_code;
	logic [maw_pkg::SIGN_W-1:0]   direction_held;
	logic [maw_pkg::SIGN_W-1:0]   drive_direction;
	logic [maw_pkg::DUTY_W-1:0]   duty_applied;
	logic                         drive_enabled;

	modport source (output valid, accepted, phase_code, direction_held, drive_direction,
		duty_applied, drive_enabled, input ready);
	modport sink (input valid, accepted, phase_code, direction_held, drive_direction,
		duty_applied, drive_enabled, output ready);
endinterface

interface maw_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [maw_pkg::CFG_IDX_W-1:0]   index;
	logic [maw_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### design/motor_arming_watchdog_fsm.sv
// Top level of the motor arming watchdog: command register, core, response register.
//
// One command in, one response out. A command transfer lands in the input
// register; once the response register is free or draining, the core
// evaluates it against the phase and latched setup (a handful of compares
// plus one 32-bit wrap-around subtract for the watchdog check), updates its
// state and loads the response register. So each command passes through the
// input register and then the response register, and one command per cycle
// is sustained as long as the response side keeps taking transfers. When
// the response register is held, the input register holds its command and
// cmd.ready drops only once both are full. Config registers are written over
// the cfg channel (always ready) and must only change while no command is in
// flight; a commit copies the checked values into the core.
module motor_arming_watchdog_fsm #(
	parameter logic [maw_pkg::DUTY_W-1:0] DUTY_LIMIT     = maw_pkg::DUTY_LIMIT_DEF,
	parameter logic [maw_pkg::TIME_W-1:0] WATCHDOG_LIMIT = maw_pkg::WATCHDOG_LIMIT_DEF
) (
	input logic        clk,
	input logic        arst_n,
	maw_cmd_if.sink    cmd,
	maw_rsp_if.source  rsp,
	maw_cfg_if.sink    cfg
);

	// input register
	logic           valid_s1;
	maw_pkg::cmd_t  cmd_s1;

	// response register
	logic           rsp_valid_q;
	maw_pkg::rsp_t  rsp_q;

	maw_pkg::cfg_t  cfg_regs;
	maw_pkg::rsp_t  result;
	logic           advance;
	logic           cmd_xfer;

	// the held command moves on whenever the response slot is free or draining
	assign advance  = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign cmd_xfer = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			cmd_s1.kind              <= cmd.kind;
			cmd_s1.direction_request <= cmd.direction_request;
			cmd_s1.duty_request      <= cmd.duty_request;
			cmd_s1.time_now          <= cmd.time_now;
		end
	end

	assign cfg.ready = 1'b1;

	maw_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	maw_core #(
		.DUTY_LIMIT     (DUTY_LIMIT),
		.WATCHDOG_LIMIT (WATCHDOG_LIMIT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.cmd    (cmd_s1),
		.cfg    (cfg_regs),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= result;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.accepted        = rsp_q.accepted;
	assign rsp.phase_code      = rsp_q.phase_code;
	assign rsp.direction_held  = rsp_q.direction_held;
	assign rsp.drive_direction = rsp_q.drive_direction;
	assign rsp.duty_applied    = rsp_q.duty_applied;
	assign rsp.drive_enabled   = rsp_q.drive_enabled;

	// output is only ever live in the running phase
	a_enable_running: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.drive_enabled |-> rsp.phase_code == maw_pkg::PH_RUNNING)
		else $error("drive enabled outside running phase");

	// duty and electrical direction are cleared together with the enable
	a_enable_duty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.drive_enabled == (rsp.duty_applied != '0)) &&
		(rsp.drive_enabled == (rsp.drive_direction != maw_pkg::SIGN_ZERO)))
		else $error("drive fields out of step with enable");

	// a held command is never dropped while the response side stalls
	a_hold_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(cmd_s1))
		else $error("stalled command lost");

endmodule

### design/maw_cfg_regs.sv
// Configuration register file, written through the config channel.
module maw_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [maw_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [maw_pkg::CFG_DATA_W-1:0]  wr_data,
	output maw_pkg::cfg_t                   cfg
);

	maw_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (maw_pkg::cfg_idx_t'(wr_index))
				maw_pkg::CFG_CONNECTOR: begin
					cfg_q.connector_number <= wr_data[maw_pkg::CONN_W-1:0];
				end
				maw_pkg::CFG_MOTOR_POL: begin
					cfg_q.motor_polarity <= wr_data[maw_pkg::SIGN_W-1:0];
				end
				maw_pkg::CFG_ENC_POL: begin
					cfg_q.encoder_polarity <= wr_data[maw_pkg::SIGN_W-1:0];
				end
				maw_pkg::CFG_CEILING: begin
					cfg_q.duty_ceiling <= wr_data[maw_pkg::DUTY_W-1:0];
				end
				maw_pkg::CFG_WATCHDOG: begin
					cfg_q.watchdog_period <= wr_data[maw_pkg::TIME_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/maw_core.sv
// Phase machine and drive state: evaluates one command and updates state.
module maw_core #(
	parameter logic [maw_pkg::DUTY_W-1:0] DUTY_LIMIT     = maw_pkg::DUTY_LIMIT_DEF,
	parameter logic [maw_pkg::TIME_W-1:0] WATCHDOG_LIMIT = maw_pkg::WATCHDOG_LIMIT_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  maw_pkg::cmd_t  cmd,
	input  maw_pkg::cfg_t  cfg,
	output maw_pkg::rsp_t  result
);

	maw_pkg::phase_t               phase_q, phase_d;
	logic                          setup_q, setup_d;
	logic [maw_pkg::TIME_W-1:0]    hb_q, hb_d;
	logic [maw_pkg::SIGN_W-1:0]    hdir_q, hdir_d;
	logic [maw_pkg::SIGN_W-1:0]    ddir_q, ddir_d;
	logic [maw_pkg::DUTY_W-1:0]    hduty_q, hduty_d;
	logic                          on_q, on_d;
	logic [maw_pkg::DUTY_W-1:0]    ceil_q, ceil_d;
	logic [maw_pkg::SIGN_W-1:0]    pol_q, pol_d;
	logic [maw_pkg::TIME_W-1:0]    tmo_q, tmo_d;
	logic                          ok;

	logic                          active;
	logic                          commit_ok;
	logic                          arm_ok;
	logic                          run_ok;
	logic                          overdue;
	logic [maw_pkg::TIME_W-1:0]    elapsed;

	assign active = (phase_q == maw_pkg::PH_ARMED) || (phase_q == maw_pkg::PH_RUNNING);

	assign commit_ok = (cfg.connector_number >= maw_pkg::CONN_MIN) &&
		(cfg.connector_number <= maw_pkg::CONN_MAX) &&
		maw_pkg::sign_ok(cfg.motor_polarity) && maw_pkg::sign_ok(cfg.encoder_polarity) &&
		(cfg.duty_ceiling != '0) && (cfg.duty_ceiling <= DUTY_LIMIT) &&
		(cfg.watchdog_period != '0) && (cfg.watchdog_period <= WATCHDOG_LIMIT);

	assign arm_ok = setup_q && (phase_q == maw_pkg::PH_DISARMED);

	assign run_ok = setup_q && active && maw_pkg::sign_ok(cmd.direction_request) &&
		(cmd.duty_request != '0) && (cmd.duty_request <= ceil_q);

	// wraps modulo 2^32
	assign elapsed = cmd.time_now - hb_q;
	assign overdue = active && (elapsed > tmo_q);

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (maw_pkg::kind_t'(cmd.kind))
			maw_pkg::KIND_COMMIT: begin
				phase_d = commit_ok ? maw_pkg::PH_DISARMED : maw_pkg::PH_FAULT;
			end
			maw_pkg::KIND_ARM: begin
				if (arm_ok) phase_d = maw_pkg::PH_ARMED;
			end
			maw_pkg::KIND_RUN: begin
				phase_d = run_ok ? maw_pkg::PH_RUNNING : maw_pkg::PH_FAULT;
			end
			maw_pkg::KIND_STOP: begin
				phase_d = setup_q ? maw_pkg::PH_DISARMED : maw_pkg::PH_UNCONF;
			end
			maw_pkg::KIND_RESET: begin
				phase_d = maw_pkg::PH_UNCONF;
			end
			maw_pkg::KIND_SERVICE: begin
				if (setup_q && overdue) phase_d = maw_pkg::PH_FAULT;
			end
			default: begin
			end
		endcase
	end

	// drive, latch and status updates
	always_comb begin
		setup_d = setup_q;
		hb_d    = hb_q;
		hdir_d  = hdir_q;
		ddir_d  = ddir_q;
		hduty_d = hduty_q;
		on_d    = on_q;
		ceil_d  = ceil_q;
		pol_d   = pol_q;
		tmo_d   = tmo_q;
		ok      = 1'b0;
		case (maw_pkg::kind_t'(cmd.kind))
			maw_pkg::KIND_COMMIT: begin
				hdir_d  = maw_pkg::SIGN_ZERO;
				ddir_d  = maw_pkg::SIGN_ZERO;
				hduty_d = '0;
				on_d    = 1'b0;
				if (commit_ok) begin
					ceil_d  = cfg.duty_ceiling;
					pol_d   = cfg.motor_polarity;
					tmo_d   = cfg.watchdog_period;
					setup_d = 1'b1;
					hb_d    = cmd.time_now;
					ok      = 1'b1;
				end else begin
					ceil_d  = '0;
					pol_d   = maw_pkg::SIGN_ZERO;
					tmo_d   = '0;
					setup_d = 1'b0;
					hb_d    = '0;
				end
			end
			maw_pkg::KIND_ARM: begin
				if (arm_ok) begin
					hdir_d  = maw_pkg::SIGN_ZERO;
					ddir_d  = maw_pkg::SIGN_ZERO;
					hduty_d = '0;
					on_d    = 1'b0;
					hb_d    = cmd.time_now;
					ok      = 1'b1;
				end
			end
			maw_pkg::KIND_RUN: begin
				if (run_ok) begin
					hdir_d  = cmd.direction_request;
					// product of two unit signs
					ddir_d  = (cmd.direction_request == pol_q) ? maw_pkg::SIGN_POS
						: maw_pkg::SIGN_NEG;
					hduty_d = cmd.duty_request;
					on_d    = 1'b1;
					hb_d    = cmd.time_now;
					ok      = 1'b1;
				end else begin
					hdir_d  = maw_pkg::SIGN_ZERO;
					ddir_d  = maw_pkg::SIGN_ZERO;
					hduty_d = '0;
					on_d    = 1'b0;
				end
			end
			maw_pkg::KIND_HEARTBEAT: begin
				if (active) begin
					hb_d = cmd.time_now;
					ok   = 1'b1;
				end
			end
			maw_pkg::KIND_STOP: begin
				hdir_d  = maw_pkg::SIGN_ZERO;
				ddir_d  = maw_pkg::SIGN_ZERO;
				hduty_d = '0;
				on_d    = 1'b0;
				ok      = 1'b1;
			end
			maw_pkg::KIND_RESET: begin
				setup_d = 1'b0;
				hb_d    = '0;
				hdir_d  = maw_pkg::SIGN_ZERO;
				ddir_d  = maw_pkg::SIGN_ZERO;
				hduty_d = '0;
				on_d    = 1'b0;
				ceil_d  = '0;
				pol_d   = maw_pkg::SIGN_ZERO;
				tmo_d   = '0;
				ok      = 1'b1;
			end
			maw_pkg::KIND_SERVICE: begin
				if (setup_q) begin
					if (overdue) begin
						hdir_d  = maw_pkg::SIGN_ZERO;
						ddir_d  = maw_pkg::SIGN_ZERO;
						hduty_d = '0;
						on_d    = 1'b0;
					end else begin
						ok = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= maw_pkg::PH_UNCONF;
			setup_q <= 1'b0;
			hb_q    <= '0;
			hdir_q  <= maw_pkg::SIGN_ZERO;
			ddir_q  <= maw_pkg::SIGN_ZERO;
			hduty_q <= '0;
			on_q    <= 1'b0;
			ceil_q  <= '0;
			pol_q   <= maw_pkg::SIGN_ZERO;
			tmo_q   <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			setup_q <= setup_d;
			hb_q    <= hb_d;
			hdir_q  <= hdir_d;
			ddir_q  <= ddir_d;
			hduty_q <= hduty_d;
			on_q    <= on_d;
			ceil_q  <= ceil_d;
			pol_q   <= pol_d;
			tmo_q   <= tmo_d;
		end
	end

	always_comb begin
		result.accepted        = ok;
		result.phase_code      = phase_d;
		result.direction_held  = hdir_d;
		result.drive_direction = ddir_d;
		result.duty_applied    = hduty_d;
		result.drive_enabled   = on_d;
	end

endmodule

### sim/maw_checker.sv
// Checker: shadows the registers, predicts each status transfer and compares it.
module maw_checker
	import maw_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	maw_cmd_if   cmd,
	maw_rsp_if   rsp,
	maw_cfg_if   cfg,
	output int   mismatches,
	output int   outstanding
);

	localparam int REPORT_MAX = 10;

	// register shadow and guard state
	cfg_t              regs;
	phase_t            ph;
	logic              setup_ok;
	logic [TIME_W-1:0] hb_time;
	logic [SIGN_W-1:0] dir_hold;
	logic [SIGN_W-1:0] dir_drive;
	logic [DUTY_W-1:0] duty_hold;
	logic              out_on;
	logic [DUTY_W-1:0] lat_ceiling;
	logic [SIGN_W-1:0] lat_pol;
	logic [TIME_W-1:0] lat_timeout;

	rsp_t due_status[$];
	int   err_count = 0;
	cmd_t seen_cmd;
	rsp_t want;

	task automatic drop_drive();
		dir_hold  = SIGN_ZERO;
		dir_drive = SIGN_ZERO;
		duty_hold = '0;
		out_on    = 1'b0;
	endtask

	task automatic wipe_state();
		ph          = PH_UNCONF;
		setup_ok    = 1'b0;
		hb_time     = '0;
		lat_ceiling = '0;
		lat_pol     = SIGN_ZERO;
		lat_timeout = '0;
		drop_drive();
	endtask

	task automatic predict_status(input cmd_t c, output rsp_t r);
		logic ok;
		logic active;
		logic regs_good;
		logic dir_good;
		ok        = 1'b0;
		active    = (ph == PH_ARMED) || (ph == PH_RUNNING);
		regs_good = (regs.connector_number >= CONN_MIN) && (regs.connector_number <= CONN_MAX)
			&& (regs.motor_polarity == SIGN_POS || regs.motor_polarity == SIGN_NEG)
			&& (regs.encoder_polarity == SIGN_POS || regs.encoder_polarity == SIGN_NEG)
			&& (regs.duty_ceiling != '0) && (regs.duty_ceiling <= DUTY_LIMIT_DEF)
			&& (regs.watchdog_period != '0) && (regs.watchdog_period <= WATCHDOG_LIMIT_DEF);
		dir_good  = (c.direction_request == SIGN_POS) || (c.direction_request == SIGN_NEG);
		case (c.kind)
			KIND_COMMIT: begin
				if (!regs_good) begin
					wipe_state();
					ph = PH_FAULT;
				end else begin
					drop_drive();
					lat_ceiling = regs.duty_ceiling;
					lat_pol     = regs.motor_polarity;
					lat_timeout = regs.watchdog_period;
					setup_ok    = 1'b1;
					ph          = PH_DISARMED;
					hb_time     = c.time_now;
					ok          = 1'b1;
				end
			end
			KIND_ARM: begin
				if (setup_ok && ph == PH_DISARMED) begin
					drop_drive();
					ph      = PH_ARMED;
					hb_time = c.time_now;
					ok      = 1'b1;
				end
			end
			KIND_RUN: begin
				if (!setup_ok || !active || !dir_good || c.duty_request == '0
						|| c.duty_request > lat_ceiling) begin
					drop_drive();
					ph = PH_FAULT;
				end else begin
					dir_hold  = c.direction_request;
					// negative motor sign flips the electrical direction
					dir_drive = (lat_pol == SIGN_NEG) ? -c.direction_request : c.direction_request;
					duty_hold = c.duty_request;
					out_on    = 1'b1;
					hb_time   = c.time_now;
					ph        = PH_RUNNING;
					ok        = 1'b1;
				end
			end
			KIND_HEARTBEAT: begin
				if (active) begin
					hb_time = c.time_now;
					ok      = 1'b1;
				end
			end
			KIND_STOP: begin
				drop_drive();
				ph = setup_ok ? PH_DISARMED : PH_UNCONF;
				ok = 1'b1;
			end
			KIND_RESET: begin
				wipe_state();
				ok = 1'b1;
			end
			KIND_SERVICE: begin
				if (setup_ok) begin
					// elapsed time wraps at 32 bits
					if (active && (c.time_now - hb_time) > lat_timeout) begin
						drop_drive();
						ph = PH_FAULT;
					end else begin
						ok = 1'b1;
					end
				end
			end
			default: ;
		endcase
		r.accepted        = ok;
		r.phase_code      = ph;
		r.direction_held  = dir_hold;
		r.drive_direction = dir_drive;
		r.duty_applied    = duty_hold;
		r.drive_enabled   = out_on;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '0;
			wipe_state();
			due_status.delete();
			outstanding <= 0;
			mismatches  <= err_count;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_CONNECTOR: regs.connector_number = cfg.data[CONN_W-1:0];
					CFG_MOTOR_POL: regs.motor_polarity   = cfg.data[SIGN_W-1:0];
					CFG_ENC_POL:   regs.encoder_polarity = cfg.data[SIGN_W-1:0];
					CFG_CEILING:   regs.duty_ceiling     = cfg.data[DUTY_W-1:0];
					CFG_WATCHDOG:  regs.watchdog_period  = cfg.data[TIME_W-1:0];
					default: ;
				endcase
			end

			if (rsp.valid && rsp.ready) begin
				if (due_status.size() == 0) begin
					err_count++;
					if (err_count <= REPORT_MAX)
						$display("[%0t] status transfer with nothing pending", $time);
				end else begin
					want = due_status.pop_front();
					if (rsp.accepted !== want.accepted || rsp.phase_code !== want.phase_code
							|| rsp.direction_held !== want.direction_held
							|| rsp.drive_direction !== want.drive_direction
							|| rsp.duty_applied !== want.duty_applied
							|| rsp.drive_enabled !== want.drive_enabled) begin
						err_count++;
						if (err_count <= REPORT_MAX) begin
							$display("[%0t] status mismatch exp: acc=%0d phase=%0d dir=%0d drv=%0d duty=%0d en=%0d",
								$time, want.accepted, want.phase_code, $signed(want.direction_held),
								$signed(want.drive_direction), want.duty_applied, want.drive_enabled);
							$display("[%0t] status mismatch got: acc=%0d phase=%0d dir=%0d drv=%0d duty=%0d en=%0d",
								$time, rsp.accepted, rsp.phase_code, $signed(rsp.direction_held),
								$signed(rsp.drive_direction), rsp.duty_applied, rsp.drive_enabled);
						end
					end
				end
			end

			if (cmd.valid && cmd.ready) begin
				seen_cmd.kind              = cmd.kind;
				seen_cmd.direction_request = cmd.direction_request;
				seen_cmd.duty_request      = cmd.duty_request;
				seen_cmd.time_now          = cmd.time_now;
				predict_status(seen_cmd, want);
				due_status.push_back(want);
			end

			mismatches  <= err_count;
			outstanding <= due_status.size();
		end
	end

endmodule

### sim/testbench.sv
// Testbench top: clock, reset, command/config stimulus, status back-pressure, verdict.
module testbench;
	import maw_pkg::*;

	// pacing knobs
	localparam int IDLE_PCT     = 22;        // chance in 100 of an idle cycle on either side
	localparam int HOLD_CYCLES  = 60;        // long status back-pressure stretch
	localparam int DRAIN_CYCLES = 6;         // settle time after the last status has come back
	localparam int SETUPS       = 20;        // register settings in the random part
	localparam int FAULT_ITEMS  = 15;        // commands per broken setting
	localparam int GOOD_ITEMS   = 84;        // commands per valid setting
	localparam int RUN_LIMIT    = 2_000_000; // hard stop, in time units

	// codes the package has no name for
	localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
	localparam logic [SIGN_W-1:0] SIGN_BAD    = 2'b10;

	logic clk = 1'b0;
	logic arst_n;

	maw_cmd_if cmd_ch ();
	maw_rsp_if rsp_ch ();
	maw_cfg_if cfg_ch ();

	int fail_total;
	int due_count;

	motor_arming_watchdog_fsm uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	maw_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_ch),
		.rsp         (rsp_ch),
		.cfg         (cfg_ch),
		.mismatches  (fail_total),
		.outstanding (due_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// steady: no idle cycles on either side; stall_asks: request a long status hold
	bit                steady = 1'b0;
	int                stall_asks = 0;
	int                stall_served = 0;
	int                items_sent = 0;
	int                settings_used = 0;
	logic [TIME_W-1:0] ms_now;
	logic [TIME_W-1:0] hb_mark;
	logic [DUTY_W-1:0] cur_ceiling;
	logic [TIME_W-1:0] cur_period;

	// Status side. A requested hold is timed here, in cycles, while the
	// sender keeps offering commands: the two internal registers fill and
	// cmd.ready must drop.
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_asks != stall_served) begin
				stall_served = stall_asks;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// One command transfer, with random idle cycles ahead of it. valid stays
	// high after the transfer so back-to-back commands never toggle it.
	task automatic issue(input logic [KIND_W-1:0] k, input logic [SIGN_W-1:0] d,
			input logic [DUTY_W-1:0] u, input logic [TIME_W-1:0] t);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid             <= 1'b1;
		cmd_ch.kind              <= k;
		cmd_ch.direction_request <= d;
		cmd_ch.duty_request      <= u;
		cmd_ch.time_now          <= t;
		do @(posedge clk); while (!cmd_ch.ready);
		items_sent++;
		// rough copy of the heartbeat stamp, used to aim service ticks at the deadline
		if (k == KIND_COMMIT || k == KIND_ARM || k == KIND_RUN || k == KIND_HEARTBEAT)
			hb_mark = t;
		ms_now = t + $urandom_range(0, 4);
	endtask

	// Stop offering and wait until every predicted status has come back.
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (due_count != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= d;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	// All five registers, only ever called with nothing in flight.
	task automatic write_setup(input logic [CONN_W-1:0] conn, input logic [SIGN_W-1:0] mpol,
			input logic [SIGN_W-1:0] epol, input logic [DUTY_W-1:0] ceil,
			input logic [TIME_W-1:0] period);
		write_reg(CFG_CONNECTOR, CFG_DATA_W'(conn));
		write_reg(CFG_MOTOR_POL, CFG_DATA_W'(mpol));
		write_reg(CFG_ENC_POL, CFG_DATA_W'(epol));
		write_reg(CFG_CEILING, CFG_DATA_W'(ceil));
		write_reg(CFG_WATCHDOG, period);
		cfg_ch.valid <= 1'b0;
		cur_ceiling = ceil;
		cur_period  = period;
		settings_used++;
	endtask

	function automatic logic [SIGN_W-1:0] unit_dir();
		return $urandom_range(0, 1) ? SIGN_POS : SIGN_NEG;
	endfunction

	// any 2-bit sign pattern, including zero and the invalid one
	function automatic logic [SIGN_W-1:0] any_sign();
		return SIGN_W'($urandom_range(0, 3));
	endfunction

	function automatic logic [DUTY_W-1:0] any_duty();
		return DUTY_W'($urandom_range(0, 2047));
	endfunction

	function automatic logic [DUTY_W-1:0] run_duty();
		if ($urandom_range(0, 3) == 0)
			return cur_ceiling;
		return DUTY_W'($urandom_range(1, (cur_ceiling == '0) ? 1 : int'(cur_ceiling)));
	endfunction

	// service tick aimed at, just inside, just past or somewhere before the deadline
	function automatic logic [TIME_W-1:0] service_time();
		case ($urandom_range(0, 3))
			0: return hb_mark + cur_period;
			1: return hb_mark + cur_period + 1;
			2: return hb_mark + cur_period - 1;
			default: return hb_mark + $urandom_range(0, cur_period);
		endcase
	endfunction

	task automatic noise_cmd();
		issue(KIND_W'($urandom_range(0, 7)), any_sign(), any_duty(), $urandom);
	endtask

	// One arming session: commit, arm, a mix of run/heartbeat/service with
	// some broken commands and noise, then mostly a stop or a reset.
	task automatic session();
		int r;
		if ($urandom_range(0, 9) == 0)
			ms_now = 32'hFFFF_FFF8; // cross the timestamp wrap
		issue(KIND_COMMIT, any_sign(), any_duty(), ms_now);
		issue(KIND_ARM, any_sign(), any_duty(), ms_now);
		repeat ($urandom_range(2, 10)) begin
			r = $urandom_range(0, 99);
			if (r < 35) begin
				issue(KIND_RUN, unit_dir(), run_duty(), ms_now);
			end else if (r < 55) begin
				issue(KIND_HEARTBEAT, any_sign(), any_duty(), ms_now);
			end else if (r < 75) begin
				issue(KIND_SERVICE, any_sign(), any_duty(), service_time());
			end else if (r < 82) begin
				case ($urandom_range(0, 3))
					0: issue(KIND_RUN, SIGN_ZERO, run_duty(), ms_now);
					1: issue(KIND_RUN, SIGN_BAD, run_duty(), ms_now);
					2: issue(KIND_RUN, unit_dir(), '0, ms_now);
					default: issue(KIND_RUN, unit_dir(), cur_ceiling + 1'b1, ms_now);
				endcase
			end else if (r < 88) begin
				issue(KIND_STOP, any_sign(), any_duty(), ms_now);
				issue(KIND_ARM, any_sign(), any_duty(), ms_now);
			end else begin
				noise_cmd();
			end
		end
		r = $urandom_range(0, 99);
		if (r < 50)
			issue(KIND_STOP, any_sign(), any_duty(), ms_now);
		else if (r < 70)
			issue(KIND_RESET, any_sign(), any_duty(), ms_now);
	endtask

	initial begin
		int quota;
		arst_n = 1'b0;
		cmd_ch.valid             <= 1'b0;
		cmd_ch.kind              <= KIND_STOP;
		cmd_ch.direction_request <= SIGN_ZERO;
		cmd_ch.duty_request      <= '0;
		cmd_ch.time_now          <= '0;
		cfg_ch.valid             <= 1'b0;
		cfg_ch.index             <= CFG_CONNECTOR;
		cfg_ch.data              <= '0;
		ms_now      = $urandom;
		hb_mark     = ms_now;
		cur_ceiling = '0;
		cur_period  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed: registers still at reset, nothing is valid ---
		issue(KIND_SERVICE, SIGN_ZERO, '0, '0);        // no setup: refused
		issue(KIND_ARM, SIGN_ZERO, '0, '0);            // arm refused
		issue(KIND_HEARTBEAT, SIGN_ZERO, '0, '0);      // heartbeat while not active
		issue(KIND_RUN, SIGN_POS, 11'd1, '0);          // run with no setup -> fault
		issue(KIND_COMMIT, SIGN_ZERO, '0, '0);         // all-zero registers -> commit fails
		issue(KIND_STOP, SIGN_ZERO, '0, '0);           // back to unconfigured
		issue(KIND_UNUSED, SIGN_BAD, 11'h7FF, '1);     // unknown kind ignored
		issue(KIND_RESET, SIGN_ZERO, '0, '0);
		drain();

		// --- directed: widest valid setup, negative motor sign ---
		write_setup(CONN_MAX, SIGN_NEG, SIGN_POS, DUTY_LIMIT_DEF, WATCHDOG_LIMIT_DEF);
		issue(KIND_COMMIT, SIGN_ZERO, '0, 32'hFFFF_FFF0);
		issue(KIND_ARM, SIGN_ZERO, '0, 32'hFFFF_FFF0);
		issue(KIND_RUN, SIGN_POS, DUTY_LIMIT_DEF, 32'hFFFF_FFFF);   // duty at ceiling
		issue(KIND_RUN, SIGN_NEG, 11'd1, 32'd5);                    // minimum duty, past wrap
		issue(KIND_SERVICE, SIGN_ZERO, '0, 32'd60005);              // exactly the timeout: ok
		issue(KIND_SERVICE, SIGN_ZERO, '0, 32'd60006);              // one past: watchdog trips
		issue(KIND_STOP, SIGN_ZERO, '0, 32'd60006);                 // fault -> disarmed
		issue(KIND_ARM, SIGN_ZERO, '0, '0);
		issue(KIND_RUN, SIGN_ZERO, 11'd5, '0);                      // zero direction
		issue(KIND_COMMIT, SIGN_ZERO, '0, '0);                      // recommit from fault
		issue(KIND_ARM, SIGN_ZERO, '0, '0);
		issue(KIND_RUN, SIGN_BAD, 11'd5, '0);                       // invalid sign pattern
		issue(KIND_STOP, SIGN_ZERO, '0, '0);
		issue(KIND_ARM, SIGN_ZERO, '0, '0);
		issue(KIND_RUN, SIGN_POS, '0, '0);                          // zero duty
		issue(KIND_STOP, SIGN_ZERO, '0, '0);
		issue(KIND_ARM, SIGN_ZERO, '0, '0);
		issue(KIND_RUN, SIGN_POS, DUTY_LIMIT_DEF + 1'b1, '0);      // above ceiling
		issue(KIND_RUN, SIGN_POS, 11'h7FF, '0);                     // run while in fault

		// --- random part, one register setting per pass ---
		for (int s = 0; s < SETUPS; s++) begin
			drain();
			case (s)
				0:  write_setup(CONN_MIN, SIGN_POS, SIGN_POS, 11'd1, 32'd1);
				1:  write_setup(CONN_MAX, SIGN_NEG, SIGN_NEG, DUTY_LIMIT_DEF, WATCHDOG_LIMIT_DEF);
				// each of these breaks one register (the last breaks three), so every commit fails
				2:  write_setup(3'd0, SIGN_POS, SIGN_NEG, 11'd500, 32'd100);
				3:  write_setup(3'd7, SIGN_POS, SIGN_NEG, 11'd500, 32'd100);
				4:  write_setup(3'd2, SIGN_ZERO, SIGN_NEG, 11'd500, 32'd100);
				5:  write_setup(3'd2, SIGN_BAD, SIGN_NEG, 11'd500, 32'd100);
				6:  write_setup(3'd2, SIGN_POS, SIGN_ZERO, 11'd500, 32'd100);
				7:  write_setup(3'd2, SIGN_POS, SIGN_BAD, 11'd500, 32'd100);
				8:  write_setup(3'd2, SIGN_POS, SIGN_NEG, 11'd0, 32'd100);
				9:  write_setup(3'd2, SIGN_POS, SIGN_NEG, DUTY_LIMIT_DEF + 1'b1, 32'd100);
				10: write_setup(3'd2, SIGN_POS, SIGN_NEG, 11'd500, 32'd0);
				11: write_setup(3'd2, SIGN_POS, SIGN_NEG, 11'd500, WATCHDOG_LIMIT_DEF + 1);
				12: write_setup(3'd5, SIGN_NEG, SIGN_POS, 11'h7FF, 32'hFFFF_FFFF);
				default: write_setup(CONN_W'($urandom_range(1, 4)), unit_dir(), unit_dir(),
					DUTY_W'($urandom_range(1, 1000)),
					$urandom_range(0, 1) ? $urandom_range(1, 50) : $urandom_range(1, 60000));
			endcase
			steady = (s == 13);                          // one full pass with no idle cycles
			if (s == 14 || s == 17)
				stall_asks <= stall_asks + 1;            // long status hold mid-pass
			quota = items_sent + ((s >= 2 && s <= 12) ? FAULT_ITEMS : GOOD_ITEMS);
			while (items_sent < quota)
				session();
		end
		drain();

		$display("Run covered %0d commands over %0d register settings: arming sessions,",
			items_sent, settings_used);
		$display("watchdog edges and wrap, refused runs and commits, noise and status stalls.");
		if (fail_total == 0 && due_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#(RUN_LIMIT);
		$display("Run timed out with %0d status transfers outstanding", due_count);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
